// ----- hdl/pcp_pkg.sv -----
// shared types and codes for the per-process call profiler
`timescale 1ns / 1ps

package pcp_pkg;

  localparam int KIND_W   = 3;
  localparam int PID_W    = 6;
  localparam int CID_W    = 5;
  localparam int TS_W     = 32;
  localparam int STATUS_W = 3;
  localparam int STAT_W   = 32;
  localparam int DEPTH_W  = 8;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 8'd255;

  localparam logic [KIND_W-1:0] KIND_ENTER = 3'd0;
  localparam logic [KIND_W-1:0] KIND_EXIT  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RESET = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_DONE      = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_IGNORED   = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOFRAME   = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOCHARGE  = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_SATURATED = 3'd4;

  // one open call frame on a process stack
  typedef struct packed {
    logic             counted;
    logic [CID_W-1:0] id;
    logic [TS_W-1:0]  start;
  } frame_t;

  // requests from the sequencer to the statistics memories
  typedef struct packed {
    logic rd;
    logic wr_count;
    logic wr_time;
    logic clear;
  } stat_cmd_t;

endpackage

// ----- hdl/pcp_in_if.sv -----
// input item channel of the call profiler
`timescale 1ns / 1ps

interface pcp_in_if;
  import pcp_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [PID_W-1:0]  pid;
  logic [CID_W-1:0]  call_id;
  logic [TS_W-1:0]   timestamp;

  modport source (output valid, kind, pid, call_id, timestamp, input ready);
  modport sink (input valid, kind, pid, call_id, timestamp, output ready);
endinterface

// ----- hdl/pcp_out_if.sv -----
// result item channel of the call profiler
`timescale 1ns / 1ps

interface pcp_out_if;
  import pcp_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [STAT_W-1:0]   call_count;
  logic [STAT_W-1:0]   total_time;

  modport source (output valid, status, call_count, total_time, input ready);
  modport sink (input valid, status, call_count, total_time, output ready);
endinterface

// ----- hdl/pcp_stats.sv -----
// call count and total time memories with the clearing sweep
`timescale 1ns / 1ps

module pcp_stats #(
  parameter int MAX_PROCS = 64,
  parameter int NUM_CALLS = 27
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  pcp_pkg::stat_cmd_t                     cmd_i,
  input  logic [$clog2(MAX_PROCS*NUM_CALLS+1)-1:0] rd_addr_i,
  input  logic [$clog2(MAX_PROCS*NUM_CALLS+1)-1:0] wr_addr_i,
  input  logic [pcp_pkg::STAT_W-1:0]             count_i,
  input  logic [pcp_pkg::STAT_W-1:0]             time_i,
  output logic [pcp_pkg::STAT_W-1:0]             count_o,
  output logic [pcp_pkg::STAT_W-1:0]             time_o,
  output logic                                   busy_o
);
  import pcp_pkg::*;

  localparam int NSTAT = MAX_PROCS * NUM_CALLS;
  localparam int AW    = $clog2(NSTAT + 1);
  localparam logic [AW-1:0] LAST = AW'(NSTAT - 1);

  logic [STAT_W-1:0] count_mem [NSTAT];
  logic [STAT_W-1:0] time_mem  [NSTAT];
  logic [STAT_W-1:0] count_rd_q, time_rd_q;
  logic              busy_q, busy_d;
  logic [AW-1:0]     clr_q, clr_d;

  // sweep runs after reset and on every clear request
  always_comb begin
    busy_d = busy_q;
    clr_d  = clr_q;
    if (cmd_i.clear) begin
      busy_d = 1'b1;
      clr_d  = '0;
    end else if (busy_q) begin
      if (clr_q == LAST) begin
        busy_d = 1'b0;
      end else begin
        clr_d = clr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else begin
      busy_q <= busy_d;
      clr_q  <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      count_rd_q <= count_mem[rd_addr_i];
    end
    if (busy_q) begin
      count_mem[clr_q] <= '0;
    end else if (cmd_i.wr_count) begin
      count_mem[wr_addr_i] <= count_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      time_rd_q <= time_mem[rd_addr_i];
    end
    if (busy_q) begin
      time_mem[clr_q] <= '0;
    end else if (cmd_i.wr_time) begin
      time_mem[wr_addr_i] <= time_i;
    end
  end

  assign count_o = count_rd_q;
  assign time_o  = time_rd_q;
  assign busy_o  = busy_q;

  a_no_access_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !(cmd_i.rd || cmd_i.wr_count || cmd_i.wr_time || cmd_i.clear))
    else $error("statistics accessed during clearing sweep");

  a_clear_starts_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> busy_q && clr_q == '0)
    else $error("clear request did not restart the sweep");

  a_sweep_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> clr_q <= LAST)
    else $error("sweep address beyond the memory");

endmodule

// ----- hdl/per_process_call_profiler_unit.sv -----
// top level of the per-process call profiler
//
//   channel            dir  handshake          payload
//   in_i               in   valid / ready      kind, pid, call_id, timestamp
//   out_o              out  valid / ready      status, call_count, total_time
//   trace_enable_*_i   in   write enable only  trace_enable
//
// an item passes through accept (depth and statistics read), depth lookup
// (frame read at the computed slot) and execute (write back, result registered)
// the frame address depends on the depth read, hence the separate lookup step
// after reset and after a clear statistics item the statistics memories are
// swept over all MAX_PROCS * NUM_CALLS entries, and no item is accepted meanwhile
// a stalled result register holds the item in execute; one item is accepted
// while the previous result still waits on out_o
`timescale 1ns / 1ps

module per_process_call_profiler_unit #(
  parameter int MAX_PROCS   = 64,
  parameter int NUM_CALLS   = 27,
  parameter int STACK_DEPTH = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            trace_enable_we_i,
  input  logic            trace_enable_i,
  pcp_in_if.sink          in_i,
  pcp_out_if.source       out_o
);
  import pcp_pkg::*;

  localparam int PW    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int PXW   = PW + PID_W;
  localparam int SDW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int NSTAT = MAX_PROCS * NUM_CALLS;
  localparam int SAW   = $clog2(NSTAT + 1);
  localparam int NFRM  = MAX_PROCS * STACK_DEPTH;
  localparam int FAW   = (NFRM > 1) ? $clog2(NFRM) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0]          state_q, state_d;
  logic                trace_q;
  logic                accept;
  logic                exec_fire;
  logic                out_free;

  // item held through its cycles
  logic [KIND_W-1:0]   kind_q;
  logic [PID_W-1:0]    pid_q;
  logic [CID_W-1:0]    cid_q;
  logic [TS_W-1:0]     ts_q;
  logic [SAW-1:0]      saddr_q;

  logic [PXW-1:0]      in_pid_wide, pid_wide;
  logic [PW-1:0]       in_pid_idx, pid_idx;
  logic [SAW-1:0]      in_saddr;
  logic                pid_ok, cid_ok;

  // depth memory with per-process valid bits
  logic [DEPTH_W-1:0]  depth_mem [MAX_PROCS];
  logic [DEPTH_W-1:0]  depth_rd_q;
  logic [MAX_PROCS-1:0] dvalid_q;
  logic                depth_we;
  logic [DEPTH_W-1:0]  depth_wd;
  logic                proc_clr;

  logic [DEPTH_W-1:0]  d_look, slot, d_q, d_dec;
  logic [FAW-1:0]      faddr_d, faddr_q;

  // frame memory
  frame_t              frame_mem [NFRM];
  frame_t              frame_rd_q;
  frame_t              frame_wd;
  logic                frame_we;

  stat_cmd_t           scmd;
  logic [STAT_W-1:0]   cnt_rd, tim_rd, cnt_wd, tim_wd;
  logic                stats_busy;

  logic [STATUS_W-1:0] status_d, status_q;
  logic [STAT_W-1:0]   rcount_d, rcount_q, rtime_d, rtime_q;
  logic                out_valid_q, out_valid_d;

  assign in_i.ready  = (state_q == ST_IDLE) && !stats_busy;
  assign accept      = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;
  assign exec_fire   = (state_q == ST_EXEC) && out_free;

  assign in_pid_wide = PXW'(in_i.pid);
  assign in_pid_idx  = in_pid_wide[PW-1:0];
  assign in_saddr    = SAW'(in_pid_idx) * SAW'(NUM_CALLS) + SAW'(in_i.call_id);

  assign pid_wide    = PXW'(pid_q);
  assign pid_idx     = pid_wide[PW-1:0];
  assign pid_ok      = pid_wide < PXW'(MAX_PROCS);
  assign cid_ok      = {1'b0, cid_q} < (CID_W + 1)'(NUM_CALLS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trace_q <= 1'b0;
    end else if (trace_enable_we_i) begin
      trace_q <= trace_enable_i;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_LOOK;
      ST_LOOK: state_d = ST_EXEC;
      ST_EXEC: if (exec_fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= in_i.kind;
      pid_q   <= in_i.pid;
      cid_q   <= in_i.call_id;
      ts_q    <= in_i.timestamp;
      saddr_q <= in_saddr;
    end
  end

  // depth memory: read on accept, written back on execute
  always_ff @(posedge clk_i) begin
    if (accept) begin
      depth_rd_q <= depth_mem[in_pid_idx];
    end
    if (depth_we) begin
      depth_mem[pid_idx] <= depth_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvalid_q <= '0;
    end else if (depth_we) begin
      dvalid_q[pid_idx] <= 1'b1;
    end else if (proc_clr) begin
      dvalid_q[pid_idx] <= 1'b0;
    end
  end

  // lookup: push slot is the depth, pop slot is one below
  assign d_look  = dvalid_q[pid_idx] ? depth_rd_q : '0;
  assign slot    = (kind_q == KIND_ENTER) ? d_look : d_look - DEPTH_W'(1);
  assign faddr_d = FAW'(pid_idx) * FAW'(STACK_DEPTH) + FAW'(slot[SDW-1:0]);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOOK) begin
      d_q        <= d_look;
      faddr_q    <= faddr_d;
      frame_rd_q <= frame_mem[faddr_d];
    end
    if (frame_we) begin
      frame_mem[faddr_q] <= frame_wd;
    end
  end

  assign d_dec = d_q - DEPTH_W'(1);

  always_comb begin
    status_d      = STATUS_IGNORED;
    rcount_d      = '0;
    rtime_d       = '0;
    depth_we      = 1'b0;
    depth_wd      = d_q;
    proc_clr      = 1'b0;
    frame_we      = 1'b0;
    frame_wd      = '{counted: trace_q, id: cid_q, start: ts_q};
    scmd          = '0;
    scmd.rd       = accept;
    cnt_wd        = cnt_rd + STAT_W'(1);
    tim_wd        = tim_rd + (ts_q - frame_rd_q.start);
    if (exec_fire) begin
      case (kind_q)
        KIND_ENTER: begin
          if (pid_ok && cid_ok) begin
            if (d_q == DEPTH_MAX) begin
              status_d = STATUS_SATURATED;
            end else begin
              depth_we = 1'b1;
              depth_wd = d_q + DEPTH_W'(1);
              if ({1'b0, d_q} < (DEPTH_W + 1)'(STACK_DEPTH)) begin
                frame_we      = 1'b1;
                scmd.wr_count = trace_q;
                status_d      = STATUS_DONE;
              end else begin
                status_d = STATUS_NOFRAME;
              end
            end
          end
        end
        KIND_EXIT: begin
          if (pid_ok && cid_ok && d_q != '0) begin
            depth_we = 1'b1;
            depth_wd = d_dec;
            if ({1'b0, d_dec} < (DEPTH_W + 1)'(STACK_DEPTH)) begin
              if (frame_rd_q.counted && frame_rd_q.id == cid_q) begin
                scmd.wr_time = 1'b1;
                status_d     = STATUS_DONE;
              end else begin
                status_d = STATUS_NOCHARGE;
              end
            end else begin
              status_d = STATUS_NOFRAME;
            end
          end
        end
        KIND_RESET: begin
          if (pid_ok) begin
            proc_clr = 1'b1;
            status_d = STATUS_DONE;
          end
        end
        KIND_CLEAR: begin
          scmd.clear = 1'b1;
          status_d   = STATUS_DONE;
        end
        KIND_READ: begin
          if (pid_ok && cid_ok) begin
            rcount_d = cnt_rd;
            rtime_d  = tim_rd;
            status_d = STATUS_DONE;
          end
        end
        default: status_d = STATUS_IGNORED;
      endcase
    end
  end

  pcp_stats #(
    .MAX_PROCS (MAX_PROCS),
    .NUM_CALLS (NUM_CALLS)
  ) u_stats (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (scmd),
    .rd_addr_i (in_saddr),
    .wr_addr_i (saddr_q),
    .count_i   (cnt_wd),
    .time_i    (tim_wd),
    .count_o   (cnt_rd),
    .time_o    (tim_rd),
    .busy_o    (stats_busy)
  );

  // result register
  assign out_valid_d = exec_fire ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      status_q <= status_d;
      rcount_q <= rcount_d;
      rtime_q  <= rtime_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = status_q;
  assign out_o.call_count = rcount_q;
  assign out_o.total_time = rtime_q;

  a_accept_to_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_LOOK)
    else $error("accepted item did not move to depth lookup");

  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire && kind_q == KIND_CLEAR |=> stats_busy && !in_i.ready)
    else $error("input open while statistics are being cleared");

  a_exec_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC && !out_free |=> state_q == ST_EXEC && $stable(faddr_q))
    else $error("stalled item left execute");

  a_one_depth_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(depth_we && proc_clr))
    else $error("depth written and process reset together");

endmodule
